@@ src/scl_pkg.sv @@
// Shared types, character codes and helper functions for the source code lexer.
package scl_pkg;

    // Lexer modes
    typedef enum logic [3:0]
    {
        M_DEFAULT = 4'd0,
        M_IDENT   = 4'd1,
        M_INT     = 4'd2,
        M_INT_DOT = 4'd3,
        M_FLOAT   = 4'd4,
        M_GT      = 4'd5,
        M_LT      = 4'd6,
        M_EQ      = 4'd7,
        M_STRING  = 4'd8,
        M_COMMENT = 4'd9
    } mode_t;

    // Token kinds
    localparam logic [4:0] K_IDENT     = 5'd0;
    localparam logic [4:0] K_KW_BOOL   = 5'd1;
    localparam logic [4:0] K_KW_TYPE   = 5'd2;
    localparam logic [4:0] K_NEG       = 5'd3;
    localparam logic [4:0] K_EQUALS    = 5'd4;
    localparam logic [4:0] K_OP        = 5'd5;
    localparam logic [4:0] K_SEMI      = 5'd6;
    localparam logic [4:0] K_FLOAT     = 5'd7;
    localparam logic [4:0] K_INT       = 5'd8;
    localparam logic [4:0] K_LPAREN    = 5'd9;
    localparam logic [4:0] K_RPAREN    = 5'd10;
    localparam logic [4:0] K_STR_START = 5'd11;
    localparam logic [4:0] K_STR_CHAR  = 5'd12;
    localparam logic [4:0] K_STR_END   = 5'd13;
    localparam logic [4:0] K_COM_START = 5'd14;
    localparam logic [4:0] K_COM_END   = 5'd15;
    localparam logic [4:0] K_ERROR     = 5'd16;
    localparam logic [4:0] K_EOF       = 5'd17;

    // Operator codes
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_GT  = 4'd4;
    localparam logic [3:0] OP_GE  = 4'd5;
    localparam logic [3:0] OP_LT  = 4'd6;
    localparam logic [3:0] OP_LE  = 4'd7;
    localparam logic [3:0] OP_EQ  = 4'd8;

    // Error codes
    localparam logic ERR_BAD_CHAR    = 1'b0;
    localparam logic ERR_NL_IN_STRING = 1'b1;

    // Configuration register indexes
    localparam int unsigned KEYWORD_REGS = 6;
    localparam logic [3:0] REG_CLASS_BITS = 4'd6;
    localparam logic [3:0] REG_FIRST_LINE = 4'd7;

    localparam int unsigned MAX_RESULTS = 4;

    // Character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef struct packed
    {
        logic [7:0] char_byte;
        logic       end_of_source;
    } byte_item_t;

    typedef struct packed
    {
        logic [4:0]  token_kind;
        logic [3:0]  operator_code;
        logic        error_code;
        logic [23:0] lexeme_start;
        logic [15:0] lexeme_length;
        logic [15:0] line_number;
        logic [7:0]  string_char;
        logic        last_of_run;
    } token_item_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        logic [7:0] d;
        d = CH_BSLASH;
        if (c == CH_LOW_N)
            d = CH_LF;
        else if (c == CH_LOW_T)
            d = CH_TAB;
        else if (c == CH_LOW_R)
            d = CH_CR;
        else if (c == CH_QUOTE)
            d = CH_QUOTE;
        return d;
    endfunction

endpackage

@@ src/scl_core.sv @@
// Lexer state registers and the per-byte classify and emit logic.
module scl_core #(
    parameter int POSITION_BITS = 24,
    parameter int KEYWORD_SLOTS = 6,
    parameter int KEYWORD_CHARS = 8,
    parameter int LINE_BITS     = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  scl_pkg::byte_item_t      item,
    input  logic [63:0]              kw_words [scl_pkg::KEYWORD_REGS],
    input  logic [5:0]               kw_class,
    input  logic [15:0]              first_line,
    input  logic                     line_load,
    output scl_pkg::token_item_t     res [scl_pkg::MAX_RESULTS],
    output logic [2:0]               res_cnt
);

    localparam int CHW = 8 * KEYWORD_CHARS;

    typedef struct packed
    {
        logic [1:0]           cnt;
        scl_pkg::token_item_t a;
        scl_pkg::token_item_t b;
    } flush_t;

    scl_pkg::mode_t             mode_reg, mode_next;
    logic [POSITION_BITS-1:0]   pstart_reg, pstart_next;
    logic [15:0]                plen_reg, plen_next;
    logic [CHW-1:0]             pchars_reg, pchars_next;
    logic                       toolong_reg, toolong_next;
    logic [POSITION_BITS-1:0]   bpos_reg, bpos_next;
    logic [LINE_BITS-1:0]       line_reg, line_next;
    logic                       esc_reg, esc_next;

    function automatic scl_pkg::token_item_t mk(
        input logic [4:0]               kind,
        input logic [3:0]               op,
        input logic                     err,
        input logic [POSITION_BITS-1:0] start,
        input logic [15:0]              len,
        input logic [LINE_BITS-1:0]     ln,
        input logic [7:0]               sch
    );
        scl_pkg::token_item_t t;
        t.token_kind    = kind;
        t.operator_code = op;
        t.error_code    = err;
        t.lexeme_start  = 24'(start);
        t.lexeme_length = len;
        t.line_number   = 16'(ln);
        t.string_char   = sch;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    // Match the pending identifier against the keyword slots, lowest slot wins
    function automatic logic [4:0] ident_kind(input logic [CHW-1:0] ch, input logic tl);
        logic [4:0] k;
        k = scl_pkg::K_IDENT;
        if (!tl)
        begin
            for (int i = KEYWORD_SLOTS - 1; i >= 0; i--)
            begin
                if (kw_words[i] != 64'd0 && kw_words[i] == 64'(ch))
                    k = kw_class[i] ? scl_pkg::K_KW_TYPE : scl_pkg::K_KW_BOOL;
            end
        end
        return k;
    endfunction

    // Emit whatever the pending lexeme holds
    function automatic flush_t flush_out(
        input scl_pkg::mode_t           m,
        input logic [POSITION_BITS-1:0] ps,
        input logic [15:0]              pl,
        input logic [4:0]               ikind,
        input logic [POSITION_BITS-1:0] dot,
        input logic [LINE_BITS-1:0]     ln
    );
        flush_t f;
        f.cnt = 2'd0;
        f.a   = '0;
        f.b   = '0;
        unique case (m)
            scl_pkg::M_IDENT:
            begin
                f.cnt = 2'd1;
                f.a   = mk(ikind, 4'd0, 1'b0, ps, pl, ln, 8'd0);
            end
            scl_pkg::M_INT:
            begin
                f.cnt = 2'd1;
                f.a   = mk(scl_pkg::K_INT, 4'd0, 1'b0, ps, pl, ln, 8'd0);
            end
            scl_pkg::M_INT_DOT:
            begin
                f.cnt = 2'd2;
                f.a   = mk(scl_pkg::K_INT, 4'd0, 1'b0, ps, pl, ln, 8'd0);
                f.b   = mk(scl_pkg::K_ERROR, 4'd0, scl_pkg::ERR_BAD_CHAR, dot, 16'd1, ln,
                           8'd0);
            end
            scl_pkg::M_FLOAT:
            begin
                f.cnt = 2'd1;
                f.a   = mk(scl_pkg::K_FLOAT, 4'd0, 1'b0, ps, pl, ln, 8'd0);
            end
            scl_pkg::M_GT:
            begin
                f.cnt = 2'd1;
                f.a   = mk(scl_pkg::K_OP, scl_pkg::OP_GT, 1'b0, ps, 16'd1, ln, 8'd0);
            end
            scl_pkg::M_LT:
            begin
                f.cnt = 2'd1;
                f.a   = mk(scl_pkg::K_OP, scl_pkg::OP_LT, 1'b0, ps, 16'd1, ln, 8'd0);
            end
            scl_pkg::M_EQ:
            begin
                f.cnt = 2'd1;
                f.a   = mk(scl_pkg::K_EQUALS, 4'd0, 1'b0, ps, 16'd1, ln, 8'd0);
            end
            scl_pkg::M_COMMENT:
            begin
                if (pl != 16'd0)
                begin
                    f.cnt = 2'd1;
                    f.a   = mk(scl_pkg::K_COM_END, 4'd0, 1'b0, ps, pl, ln, 8'd0);
                end
            end
            default:
            begin
                f.cnt = 2'd0;
            end
        endcase
        return f;
    endfunction

    // Classify the byte and build the results for it
    always_comb
    begin
        logic [7:0]               c;
        logic [POSITION_BITS-1:0] pos, prev, posn;
        logic [2:0]               n;
        logic                     saw_space, do_fl, do_def;
        logic [16:0]              sum2;
        flush_t                   f;

        c         = item.char_byte;
        pos       = bpos_reg;
        prev      = bpos_reg - POSITION_BITS'(1);
        posn      = bpos_reg + POSITION_BITS'(1);
        n         = 3'd0;
        saw_space = 1'b0;
        do_fl     = 1'b0;
        do_def    = 1'b0;
        sum2      = 17'(plen_reg) + 17'd2;
        f         = '0;
        for (int i = 0; i < scl_pkg::MAX_RESULTS; i++)
            res[i] = '0;

        mode_next    = mode_reg;
        pstart_next  = pstart_reg;
        plen_next    = plen_reg;
        pchars_next  = pchars_reg;
        toolong_next = toolong_reg;
        line_next    = line_reg;
        esc_next     = esc_reg;
        bpos_next    = bpos_reg;

        unique case (mode_reg)
            scl_pkg::M_IDENT:
            begin
                if (scl_pkg::is_alpha(c) || scl_pkg::is_digit(c) || c == scl_pkg::CH_UNDER)
                begin
                    if (!toolong_reg && plen_reg < 16'(KEYWORD_CHARS))
                    begin
                        for (int j = 0; j < KEYWORD_CHARS; j++)
                            if (plen_reg == 16'(j))
                                pchars_next[8*j +: 8] = c;
                    end
                    else
                        toolong_next = 1'b1;
                    plen_next = (plen_reg == 16'hFFFF) ? 16'hFFFF : plen_reg + 16'd1;
                end
                else
                    do_fl = 1'b1;
            end
            scl_pkg::M_INT:
            begin
                if (scl_pkg::is_digit(c))
                    plen_next = (plen_reg == 16'hFFFF) ? 16'hFFFF : plen_reg + 16'd1;
                else if (c == scl_pkg::CH_DOT)
                    mode_next = scl_pkg::M_INT_DOT;
                else
                    do_fl = 1'b1;
            end
            scl_pkg::M_INT_DOT:
            begin
                if (scl_pkg::is_digit(c))
                begin
                    mode_next = scl_pkg::M_FLOAT;
                    plen_next = sum2[16] ? 16'hFFFF : sum2[15:0];
                end
                else
                    do_fl = 1'b1;
            end
            scl_pkg::M_FLOAT:
            begin
                if (scl_pkg::is_digit(c))
                    plen_next = (plen_reg == 16'hFFFF) ? 16'hFFFF : plen_reg + 16'd1;
                else
                    do_fl = 1'b1;
            end
            scl_pkg::M_GT, scl_pkg::M_LT, scl_pkg::M_EQ:
            begin
                if (c == scl_pkg::CH_EQ)
                begin
                    res[0] = mk(scl_pkg::K_OP,
                                (mode_reg == scl_pkg::M_GT) ? scl_pkg::OP_GE :
                                (mode_reg == scl_pkg::M_LT) ? scl_pkg::OP_LE : scl_pkg::OP_EQ,
                                1'b0, pstart_reg, 16'd2, line_reg, 8'd0);
                    n         = 3'd1;
                    mode_next = scl_pkg::M_DEFAULT;
                end
                else
                    do_fl = 1'b1;
            end
            scl_pkg::M_STRING:
            begin
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    res[0]   = mk(scl_pkg::K_STR_CHAR, 4'd0, 1'b0, prev, 16'd2, line_reg,
                                  scl_pkg::decode_escape(c));
                    n        = 3'd1;
                end
                else if (c == scl_pkg::CH_QUOTE)
                begin
                    mode_next = scl_pkg::M_DEFAULT;
                    res[0]    = mk(scl_pkg::K_STR_END, 4'd0, 1'b0, pos, 16'd1, line_reg, 8'd0);
                    n         = 3'd1;
                end
                else if (c == scl_pkg::CH_LF)
                begin
                    line_next = line_reg + LINE_BITS'(1);
                    mode_next = scl_pkg::M_DEFAULT;
                    res[0]    = mk(scl_pkg::K_ERROR, 4'd0, scl_pkg::ERR_NL_IN_STRING, pos,
                                   16'd1, line_next, 8'd0);
                    n         = 3'd1;
                end
                else if (c == scl_pkg::CH_BSLASH)
                    esc_next = 1'b1;
                else
                begin
                    res[0] = mk(scl_pkg::K_STR_CHAR, 4'd0, 1'b0, pos, 16'd1, line_reg, c);
                    n      = 3'd1;
                end
            end
            scl_pkg::M_COMMENT:
            begin
                if (c == scl_pkg::CH_LF)
                begin
                    // comment end always goes out, with zero length for an empty body
                    res[0]    = mk(scl_pkg::K_COM_END, 4'd0, 1'b0, pstart_reg, plen_reg,
                                   line_reg, 8'd0);
                    n         = 3'd1;
                    mode_next = scl_pkg::M_DEFAULT;
                    do_def    = 1'b1;
                end
                else
                    plen_next = (plen_reg == 16'hFFFF) ? 16'hFFFF : plen_reg + 16'd1;
            end
            default:
            begin
                do_def = 1'b1;
            end
        endcase

        // Close the pending lexeme, then treat the byte as a fresh one
        if (do_fl)
        begin
            f = flush_out(mode_reg, pstart_reg, plen_reg,
                          ident_kind(pchars_reg, toolong_reg), prev, line_reg);
            if (f.cnt != 2'd0)
            begin
                res[n[1:0]] = f.a;
                n           = n + 3'd1;
            end
            if (f.cnt == 2'd2)
            begin
                res[n[1:0]] = f.b;
                n           = n + 3'd1;
            end
            mode_next = scl_pkg::M_DEFAULT;
            do_def    = 1'b1;
        end

        // Default-mode handling of the byte
        if (do_def)
        begin
            mode_next = scl_pkg::M_DEFAULT;
            if (scl_pkg::is_space(c))
            begin
                if (c == scl_pkg::CH_LF)
                    line_next = line_reg + LINE_BITS'(1);
                saw_space = 1'b1;
            end
            else if (scl_pkg::is_alpha(c) || c == scl_pkg::CH_UNDER || scl_pkg::is_digit(c)
                     || c == scl_pkg::CH_GT || c == scl_pkg::CH_LT || c == scl_pkg::CH_EQ)
            begin
                if (scl_pkg::is_digit(c))
                    mode_next = scl_pkg::M_INT;
                else if (c == scl_pkg::CH_GT)
                    mode_next = scl_pkg::M_GT;
                else if (c == scl_pkg::CH_LT)
                    mode_next = scl_pkg::M_LT;
                else if (c == scl_pkg::CH_EQ)
                    mode_next = scl_pkg::M_EQ;
                else
                    mode_next = scl_pkg::M_IDENT;
                pstart_next  = pos;
                plen_next    = 16'd1;
                pchars_next  = CHW'(c);
                toolong_next = 1'b0;
            end
            else if (c == scl_pkg::CH_QUOTE)
            begin
                mode_next   = scl_pkg::M_STRING;
                esc_next    = 1'b0;
                res[n[1:0]] = mk(scl_pkg::K_STR_START, 4'd0, 1'b0, pos, 16'd1, line_reg, 8'd0);
                n           = n + 3'd1;
            end
            else if (c == scl_pkg::CH_HASH)
            begin
                mode_next   = scl_pkg::M_COMMENT;
                pstart_next = posn;
                plen_next   = 16'd0;
                res[n[1:0]] = mk(scl_pkg::K_COM_START, 4'd0, 1'b0, pos, 16'd1, line_reg, 8'd0);
                n           = n + 3'd1;
            end
            else
            begin
                if (c == scl_pkg::CH_SEMI)
                    res[n[1:0]] = mk(scl_pkg::K_SEMI, 4'd0, 1'b0, pos, 16'd1, line_reg, 8'd0);
                else if (c == scl_pkg::CH_PLUS)
                    res[n[1:0]] = mk(scl_pkg::K_OP, scl_pkg::OP_ADD, 1'b0, pos, 16'd1,
                                     line_reg, 8'd0);
                else if (c == scl_pkg::CH_MINUS)
                    res[n[1:0]] = mk(scl_pkg::K_OP, scl_pkg::OP_SUB, 1'b0, pos, 16'd1,
                                     line_reg, 8'd0);
                else if (c == scl_pkg::CH_STAR)
                    res[n[1:0]] = mk(scl_pkg::K_OP, scl_pkg::OP_MUL, 1'b0, pos, 16'd1,
                                     line_reg, 8'd0);
                else if (c == scl_pkg::CH_SLASH)
                    res[n[1:0]] = mk(scl_pkg::K_OP, scl_pkg::OP_DIV, 1'b0, pos, 16'd1,
                                     line_reg, 8'd0);
                else if (c == scl_pkg::CH_LPAREN)
                    res[n[1:0]] = mk(scl_pkg::K_LPAREN, 4'd0, 1'b0, pos, 16'd1, line_reg, 8'd0);
                else if (c == scl_pkg::CH_RPAREN)
                    res[n[1:0]] = mk(scl_pkg::K_RPAREN, 4'd0, 1'b0, pos, 16'd1, line_reg, 8'd0);
                else if (c == scl_pkg::CH_BANG)
                    res[n[1:0]] = mk(scl_pkg::K_NEG, 4'd0, 1'b0, pos, 16'd1, line_reg, 8'd0);
                else
                    res[n[1:0]] = mk(scl_pkg::K_ERROR, 4'd0, scl_pkg::ERR_BAD_CHAR, pos, 16'd1,
                                     line_reg, 8'd0);
                n = n + 3'd1;
            end
        end

        // End of source: drain the pending lexeme, or report eof after a white space byte, then restart
        if (item.end_of_source)
        begin
            if (mode_next != scl_pkg::M_DEFAULT)
            begin
                f = flush_out(mode_next, pstart_next, plen_next,
                              ident_kind(pchars_next, toolong_next), pos, line_next);
                if (f.cnt != 2'd0)
                begin
                    res[n[1:0]] = f.a;
                    n           = n + 3'd1;
                end
                if (f.cnt == 2'd2)
                begin
                    res[n[1:0]] = f.b;
                    n           = n + 3'd1;
                end
            end
            else if (saw_space)
            begin
                res[n[1:0]] = mk(scl_pkg::K_EOF, 4'd0, 1'b0, posn, 16'd0, line_next, 8'd0);
                n           = n + 3'd1;
            end
            mode_next    = scl_pkg::M_DEFAULT;
            pstart_next  = '0;
            plen_next    = '0;
            pchars_next  = '0;
            toolong_next = 1'b0;
            esc_next     = 1'b0;
            bpos_next    = '0;
            line_next    = LINE_BITS'(first_line);
        end
        else
            bpos_next = posn;

        if (n != 3'd0)
            res[n[1:0] - 2'd1].last_of_run = 1'b1;
        res_cnt = n;
    end

    // Hold the lexer state, advance it on each committed byte unless a first-line write lands with it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= scl_pkg::M_DEFAULT;
            pstart_reg  <= '0;
            plen_reg    <= '0;
            pchars_reg  <= '0;
            toolong_reg <= 1'b0;
            bpos_reg    <= '0;
            line_reg    <= LINE_BITS'(1);
            esc_reg     <= 1'b0;
        end
        else if (line_load)
        begin
            line_reg <= LINE_BITS'(first_line);
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            pstart_reg  <= pstart_next;
            plen_reg    <= plen_next;
            pchars_reg  <= pchars_next;
            toolong_reg <= toolong_next;
            bpos_reg    <= bpos_next;
            line_reg    <= line_next;
            esc_reg     <= esc_next;
        end
    end

endmodule

@@ src/source_code_lexer_unit.sv @@
// Top level of the source code lexer: input register, config registers, result queue.
// Throughput: one byte per cycle while each byte yields at most one token and the
// receiver is ready; a byte that yields k tokens (k up to 3) holds the next byte until they drain.
// Reset: mode default, position zero, line 1, keywords cleared, queues empty.
// Lexing state sits in scl_core; results drain one per cycle from a small queue while the receiver is ready.
module source_code_lexer_unit #(
    parameter int POSITION_BITS = 24,
    parameter int KEYWORD_SLOTS = 6,
    parameter int KEYWORD_CHARS = 8,
    parameter int LINE_BITS     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  scl_pkg::byte_item_t   byte_item,
    output logic                  token_valid,
    input  logic                  token_ready,
    output scl_pkg::token_item_t  token_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    logic                  in_valid_reg;
    scl_pkg::byte_item_t   in_reg;
    logic [63:0]           kw_reg [scl_pkg::KEYWORD_REGS];
    logic [5:0]            class_reg;
    logic [15:0]           first_line_reg;
    scl_pkg::token_item_t  buf_reg [scl_pkg::MAX_RESULTS];
    logic [1:0]            rd_reg;
    logic [2:0]            rem_reg;
    scl_pkg::token_item_t  res [scl_pkg::MAX_RESULTS];
    logic [2:0]            res_cnt;
    logic                  commit;
    logic                  cfg_fire;
    logic                  out_fire;
    logic                  line_load;
    logic [15:0]           first_line_src;

    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign token_valid = rem_reg != 3'd0;
    assign token_item  = buf_reg[rd_reg];
    assign out_fire    = token_valid && token_ready;
    assign commit      = in_valid_reg && (rem_reg == 3'd0 || (rem_reg == 3'd1 && token_ready));
    assign byte_ready  = !in_valid_reg || commit;

    // Load the line counter from the write itself, reload it from the register otherwise
    assign line_load      = cfg_fire && cfg_index == scl_pkg::REG_FIRST_LINE;
    assign first_line_src = line_load ? cfg_data[15:0] : first_line_reg;

    scl_core #(
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_SLOTS (KEYWORD_SLOTS),
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LINE_BITS     (LINE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (commit),
        .item       (in_reg),
        .kw_words   (kw_reg),
        .kw_class   (class_reg),
        .first_line (first_line_src),
        .line_load  (line_load),
        .res        (res),
        .res_cnt    (res_cnt)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scl_pkg::KEYWORD_REGS; i++)
                kw_reg[i] <= '0;
            class_reg      <= '0;
            first_line_reg <= 16'd1;
        end
        else if (cfg_fire)
        begin
            for (int i = 0; i < scl_pkg::KEYWORD_REGS; i++)
                if (cfg_index == 4'(i))
                    kw_reg[i] <= cfg_data;
            if (cfg_index == scl_pkg::REG_CLASS_BITS)
                class_reg <= cfg_data[5:0];
            if (cfg_index == scl_pkg::REG_FIRST_LINE)
                first_line_reg <= cfg_data[15:0];
        end
    end

    // Hold the accepted byte until the result queue can take its tokens
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_valid && byte_ready)
            in_valid_reg <= 1'b1;
        else if (commit)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            in_reg <= byte_item;
    end

    // Load the result queue on commit, drain one token per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            rem_reg <= '0;
        end
        else if (commit)
        begin
            rd_reg  <= '0;
            rem_reg <= res_cnt;
        end
        else if (out_fire)
        begin
            rd_reg  <= rd_reg + 2'd1;
            rem_reg <= rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            buf_reg <= res;
    end

    // The stored first line follows the last write to it
    a_first_line: assert property (@(posedge clk) disable iff (!rst_n)
        line_load |=> first_line_reg == $past(cfg_data[15:0]))
        else $error("first line register missed a write");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (3'(rd_reg) + rem_reg) <= 3'(scl_pkg::MAX_RESULTS))
        else $error("result queue read past its end");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && rem_reg == 3'd1 && !commit) |=> !token_valid)
        else $error("result queue did not empty after last token");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> (in_valid_reg && rem_reg != 3'd0))
        else $error("input stalled with nothing queued");

endmodule

@@ tb/source_code_lexer_unit_tb.sv @@
// Testbench for the source code lexer: directed and random byte streams checked by a scoreboard.
`timescale 1ns / 1ps

class token_scoreboard;
    logic [63:0]          kw_words [6];
    logic [5:0]           kw_class;
    logic [15:0]          first_line;
    scl_pkg::mode_t       mode;
    logic [23:0]          lex_start;
    logic [15:0]          lex_len;
    logic [63:0]          lex_chars;
    logic                 lex_too_long;
    logic [23:0]          position;
    logic [15:0]          line_count;
    logic                 in_escape;
    logic                 space_seen;
    scl_pkg::token_item_t expected_tokens [$];
    scl_pkg::token_item_t step_tokens [$];
    int                   error_count;
    int                   token_count;
    int                   byte_count;

    function new();
        for (int i = 0; i < 6; i++)
            kw_words[i] = '0;
        kw_class = '0;
        first_line = 16'd1;
        mode = scl_pkg::M_DEFAULT;
        lex_start = '0;
        lex_len = '0;
        lex_chars = '0;
        lex_too_long = 1'b0;
        position = '0;
        line_count = 16'd1;
        in_escape = 1'b0;
        space_seen = 1'b0;
        error_count = 0;
        token_count = 0;
        byte_count = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [63:0] data);
        if (idx < scl_pkg::KEYWORD_REGS)
            kw_words[idx] = data;
        else if (idx == scl_pkg::REG_CLASS_BITS)
            kw_class = data[5:0];
        else if (idx == scl_pkg::REG_FIRST_LINE)
        begin
            first_line = data[15:0];
            line_count = data[15:0];
        end
    endfunction

    function void push(logic [4:0] kind, logic [3:0] op, logic err, logic [23:0] start,
                       logic [15:0] len, logic [7:0] sch);
        scl_pkg::token_item_t t;
        if (step_tokens.size() >= scl_pkg::MAX_RESULTS)
            return;
        t.token_kind = kind;
        t.operator_code = op;
        t.error_code = err;
        t.lexeme_start = start;
        t.lexeme_length = len;
        t.line_number = line_count;
        t.string_char = sch;
        t.last_of_run = 1'b0;
        step_tokens = {step_tokens, t};
    endfunction

    function void grow_lexeme(int n);
        if (32'(lex_len) + n > 65535)
            lex_len = 16'hFFFF;
        else
            lex_len = 16'(32'(lex_len) + n);
    endfunction

    function void open_lexeme(scl_pkg::mode_t m, logic [23:0] pos, logic [7:0] c);
        mode = m;
        lex_start = pos;
        lex_len = 16'd1;
        lex_chars = {56'd0, c};
        lex_too_long = 1'b0;
    endfunction

    function void emit_word();
        logic [4:0] kind;
        kind = scl_pkg::K_IDENT;
        if (!lex_too_long)
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (kw_words[i] != 64'd0 && kw_words[i] == lex_chars)
                begin
                    kind = kw_class[i] ? scl_pkg::K_KW_TYPE : scl_pkg::K_KW_BOOL;
                    break;
                end
            end
        end
        push(kind, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, lex_start, lex_len, 8'd0);
    endfunction

    // Emit whatever lexeme is pending and drop back to the default mode
    function void flush_lexeme(logic [23:0] dot_pos);
        case (mode)
            scl_pkg::M_IDENT:
                emit_word();
            scl_pkg::M_INT:
                push(scl_pkg::K_INT, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, lex_start,
                     lex_len, 8'd0);
            scl_pkg::M_INT_DOT:
            begin
                push(scl_pkg::K_INT, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, lex_start,
                     lex_len, 8'd0);
                push(scl_pkg::K_ERROR, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, dot_pos,
                     16'd1, 8'd0);
            end
            scl_pkg::M_FLOAT:
                push(scl_pkg::K_FLOAT, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, lex_start,
                     lex_len, 8'd0);
            scl_pkg::M_GT:
                push(scl_pkg::K_OP, scl_pkg::OP_GT, scl_pkg::ERR_BAD_CHAR, lex_start,
                     16'd1, 8'd0);
            scl_pkg::M_LT:
                push(scl_pkg::K_OP, scl_pkg::OP_LT, scl_pkg::ERR_BAD_CHAR, lex_start,
                     16'd1, 8'd0);
            scl_pkg::M_EQ:
                push(scl_pkg::K_EQUALS, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, lex_start,
                     16'd1, 8'd0);
            scl_pkg::M_COMMENT:
                if (lex_len > 16'd0)
                    push(scl_pkg::K_COM_END, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR,
                         lex_start, lex_len, 8'd0);
            default: ;
        endcase
        mode = scl_pkg::M_DEFAULT;
    endfunction

    // Push a one-byte token with no operator, error or character
    function void push_plain(logic [4:0] kind, logic [23:0] pos);
        push(kind, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, pos, 16'd1, 8'd0);
    endfunction

    function void push_op(logic [3:0] op, logic [23:0] pos);
        push(scl_pkg::K_OP, op, scl_pkg::ERR_BAD_CHAR, pos, 16'd1, 8'd0);
    endfunction

    function void plain_byte(logic [7:0] c, logic [23:0] pos);
        mode = scl_pkg::M_DEFAULT;
        if (scl_pkg::is_space(c))
        begin
            if (c == scl_pkg::CH_LF)
                line_count = line_count + 16'd1;
            space_seen = 1'b1;
            return;
        end
        if (scl_pkg::is_alpha(c) || c == scl_pkg::CH_UNDER)
        begin
            open_lexeme(scl_pkg::M_IDENT, pos, c);
            return;
        end
        if (scl_pkg::is_digit(c))
        begin
            open_lexeme(scl_pkg::M_INT, pos, c);
            return;
        end
        case (c)
            scl_pkg::CH_QUOTE:
            begin
                mode = scl_pkg::M_STRING;
                in_escape = 1'b0;
                push_plain(scl_pkg::K_STR_START, pos);
            end
            scl_pkg::CH_HASH:
            begin
                mode = scl_pkg::M_COMMENT;
                lex_start = pos + 24'd1;
                lex_len = '0;
                push_plain(scl_pkg::K_COM_START, pos);
            end
            scl_pkg::CH_SEMI:   push_plain(scl_pkg::K_SEMI, pos);
            scl_pkg::CH_PLUS:   push_op(scl_pkg::OP_ADD, pos);
            scl_pkg::CH_MINUS:  push_op(scl_pkg::OP_SUB, pos);
            scl_pkg::CH_STAR:   push_op(scl_pkg::OP_MUL, pos);
            scl_pkg::CH_SLASH:  push_op(scl_pkg::OP_DIV, pos);
            scl_pkg::CH_LPAREN: push_plain(scl_pkg::K_LPAREN, pos);
            scl_pkg::CH_RPAREN: push_plain(scl_pkg::K_RPAREN, pos);
            scl_pkg::CH_BANG:   push_plain(scl_pkg::K_NEG, pos);
            scl_pkg::CH_GT:     open_lexeme(scl_pkg::M_GT, pos, c);
            scl_pkg::CH_LT:     open_lexeme(scl_pkg::M_LT, pos, c);
            scl_pkg::CH_EQ:     open_lexeme(scl_pkg::M_EQ, pos, c);
            default:            push_plain(scl_pkg::K_ERROR, pos);
        endcase
    endfunction

    // Note one accepted byte and queue the tokens it causes
    function void note_byte(scl_pkg::byte_item_t b);
        logic [7:0]  c;
        logic [23:0] pos;
        logic [23:0] prev;
        logic [3:0]  op;
        logic [7:0]  d;
        c = b.char_byte;
        pos = position;
        prev = pos - 24'd1;
        step_tokens.delete();
        space_seen = 1'b0;
        byte_count++;
        case (mode)
            scl_pkg::M_IDENT:
                if (scl_pkg::is_alpha(c) || scl_pkg::is_digit(c) || c == scl_pkg::CH_UNDER)
                begin
                    if (!lex_too_long && lex_len < 16'd8)
                        lex_chars[lex_len*8 +: 8] = c;
                    else
                        lex_too_long = 1'b1;
                    grow_lexeme(1);
                end
                else
                begin
                    flush_lexeme(prev);
                    plain_byte(c, pos);
                end
            scl_pkg::M_INT:
                if (scl_pkg::is_digit(c))
                    grow_lexeme(1);
                else if (c == scl_pkg::CH_DOT)
                    mode = scl_pkg::M_INT_DOT;
                else
                begin
                    flush_lexeme(prev);
                    plain_byte(c, pos);
                end
            scl_pkg::M_INT_DOT:
                if (scl_pkg::is_digit(c))
                begin
                    mode = scl_pkg::M_FLOAT;
                    grow_lexeme(2);
                end
                else
                begin
                    flush_lexeme(prev);
                    plain_byte(c, pos);
                end
            scl_pkg::M_FLOAT:
                if (scl_pkg::is_digit(c))
                    grow_lexeme(1);
                else
                begin
                    flush_lexeme(prev);
                    plain_byte(c, pos);
                end
            scl_pkg::M_GT, scl_pkg::M_LT, scl_pkg::M_EQ:
                if (c == scl_pkg::CH_EQ)
                begin
                    op = (mode == scl_pkg::M_GT) ? scl_pkg::OP_GE :
                         ((mode == scl_pkg::M_LT) ? scl_pkg::OP_LE : scl_pkg::OP_EQ);
                    push(scl_pkg::K_OP, op, scl_pkg::ERR_BAD_CHAR, lex_start, 16'd2, 8'd0);
                    mode = scl_pkg::M_DEFAULT;
                end
                else
                begin
                    flush_lexeme(prev);
                    plain_byte(c, pos);
                end
            scl_pkg::M_STRING:
                if (in_escape)
                begin
                    in_escape = 1'b0;
                    case (c)
                        scl_pkg::CH_LOW_N: d = scl_pkg::CH_LF;
                        scl_pkg::CH_LOW_T: d = scl_pkg::CH_TAB;
                        scl_pkg::CH_LOW_R: d = scl_pkg::CH_CR;
                        scl_pkg::CH_QUOTE: d = scl_pkg::CH_QUOTE;
                        default:           d = scl_pkg::CH_BSLASH;
                    endcase
                    push(scl_pkg::K_STR_CHAR, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, prev,
                         16'd2, d);
                end
                else if (c == scl_pkg::CH_QUOTE)
                begin
                    mode = scl_pkg::M_DEFAULT;
                    push_plain(scl_pkg::K_STR_END, pos);
                end
                else if (c == scl_pkg::CH_LF)
                begin
                    line_count = line_count + 16'd1;
                    mode = scl_pkg::M_DEFAULT;
                    push(scl_pkg::K_ERROR, scl_pkg::OP_ADD, scl_pkg::ERR_NL_IN_STRING, pos,
                         16'd1, 8'd0);
                end
                else if (c == scl_pkg::CH_BSLASH)
                    in_escape = 1'b1;
                else
                    push(scl_pkg::K_STR_CHAR, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, pos,
                         16'd1, c);
            scl_pkg::M_COMMENT:
                if (c == scl_pkg::CH_LF)
                begin
                    if (lex_len > 16'd0)
                        flush_lexeme(prev);
                    else
                        push(scl_pkg::K_COM_END, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR,
                             lex_start, 16'd0, 8'd0);
                    plain_byte(c, pos);
                end
                else
                    grow_lexeme(1);
            default:
                plain_byte(c, pos);
        endcase

        if (b.end_of_source)
        begin
            if (mode != scl_pkg::M_DEFAULT)
                flush_lexeme(pos);
            else if (space_seen)
                push(scl_pkg::K_EOF, scl_pkg::OP_ADD, scl_pkg::ERR_BAD_CHAR, pos + 24'd1,
                     16'd0, 8'd0);
            mode = scl_pkg::M_DEFAULT;
            lex_start = '0;
            lex_len = '0;
            lex_chars = '0;
            lex_too_long = 1'b0;
            in_escape = 1'b0;
            position = '0;
            line_count = first_line;
        end
        else
            position = pos + 24'd1;

        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
        foreach (step_tokens[i])
            expected_tokens = {expected_tokens, step_tokens[i]};
    endfunction

    function void report_field(string name, longint unsigned want, longint unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        error_count++;
    endfunction

    // Compare one accepted token against the oldest expectation
    function void check_token(scl_pkg::token_item_t got);
        scl_pkg::token_item_t want;
        token_count++;
        if (expected_tokens.size() == 0)
        begin
            $display("%0t: unexpected token, expected none, actual %p", $realtime, got);
            error_count++;
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind != want.token_kind)
            report_field("token_kind", want.token_kind, got.token_kind);
        if (got.operator_code != want.operator_code)
            report_field("operator_code", want.operator_code, got.operator_code);
        if (got.error_code != want.error_code)
            report_field("error_code", want.error_code, got.error_code);
        if (got.lexeme_start != want.lexeme_start)
            report_field("lexeme_start", want.lexeme_start, got.lexeme_start);
        if (got.lexeme_length != want.lexeme_length)
            report_field("lexeme_length", want.lexeme_length, got.lexeme_length);
        if (got.line_number != want.line_number)
            report_field("line_number", want.line_number, got.line_number);
        if (got.string_char != want.string_char)
            report_field("string_char", want.string_char, got.string_char);
        if (got.last_of_run != want.last_of_run)
            report_field("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
endclass

module source_code_lexer_unit_tb;
    logic                 clk;
    logic                 rst_n;
    logic                 byte_valid;
    logic                 byte_ready;
    scl_pkg::byte_item_t  byte_item;
    logic                 token_valid;
    logic                 token_ready;
    scl_pkg::token_item_t token_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [3:0]           cfg_index;
    logic [63:0]          cfg_data;

    token_scoreboard lex_board;
    bit              calm_mode;
    int              cycle_count;

    localparam int CYCLE_LIMIT = 200000;

    source_code_lexer_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_item(byte_item),
        .token_valid(token_valid),
        .token_ready(token_ready),
        .token_item(token_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
        clk = 1'b0;

    always
        #6 clk = ~clk;

    // Check tokens and stall the receiver in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        token_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && token_valid && token_ready)
                lex_board.check_token(token_item);
            if (stall_left > 0)
                stall_left--;
            else if (!calm_mode && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            token_ready <= rst_n && (stall_left == 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hold a register write until it transfers; the valid stays up for the next write
    task automatic cfg_write(logic [3:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        lex_board.write_reg(idx, data);
    endtask

    task automatic cfg_done();
        cfg_valid <= 1'b0;
    endtask

    // Send one byte, outside calm mode sometimes with a random gap before it
    task automatic send_byte(logic [7:0] c, logic last);
        scl_pkg::byte_item_t b;
        if (!calm_mode && $urandom_range(0, 4) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
        b.char_byte = c;
        b.end_of_source = last;
        byte_valid <= 1'b1;
        byte_item <= b;
        do
            @(posedge clk);
        while (!byte_ready);
        lex_board.note_byte(b);
    endtask

    task automatic send_text(string s, logic last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        while (lex_board.expected_tokens.size() > 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pack_word(string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            w[i*8 +: 8] = s[i];
        return w;
    endfunction

    // Random fragment of well-formed source, sometimes with noise
    function automatic string random_fragment();
        string words [8];
        string s;
        words = '{"if", "int", "true", "bool_x", "longidentifier", "_a9", "x", "abcdefgh"};
        case ($urandom_range(0, 11))
            0: s = words[$urandom_range(0, 7)];
            1: s = $sformatf("%0d", $urandom_range(0, 99999));
            2: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
            3: s = "12.";
            4: s = ">=";
            5: s = "\"a\\nb\\tc\\\\d\\\"e\\q\"";
            6: s = "# note here\n";
            7: s = "\"broken\n";
            8: s = "(x<y)==!z;";
            9: s = "+-*/ = < >";
            10: s = "\t\r\n ";
            default:
            begin
                s = " ";
                s[0] = 8'($urandom_range(1, 255));
            end
        endcase
        return s;
    endfunction

    initial
    begin
        string frag;
        int sent;
        lex_board = new();
        calm_mode = 1'b0;
        cycle_count = 0;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First setting: all slots, mixed classes, extreme line number
        cfg_write(4'd0, pack_word("if"));
        cfg_write(4'd1, pack_word("int"));
        cfg_write(4'd2, pack_word("true"));
        cfg_write(4'd3, pack_word("abcdefgh"));
        cfg_write(4'd4, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(4'd5, pack_word("bool_x"));
        cfg_write(scl_pkg::REG_CLASS_BITS, 64'd42);
        cfg_write(scl_pkg::REG_FIRST_LINE, 64'd65535);
        cfg_done();

        // Directed: every token kind, escapes, comments, float and dot cases
        send_text("if int true abcdefgh bool_x zz 12.5 7.x ", 1'b0);
        send_text("\"q\\n\\t\\r\\\\\\\"\\\n\" #c\n#\n", 1'b0);
        send_text("+-*/()!;>=<=== > < = @\"s\n9.", 1'b1);
        send_text(" \t", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_text("#", 1'b1);
        send_text("\"open", 1'b1);
        drain();

        // Second setting: keywords cleared or random, line zero, all type bits
        for (int i = 0; i < 6; i++)
            cfg_write(i[3:0], $urandom_range(0, 1) ? 64'd0 : {$urandom, $urandom});
        cfg_write(scl_pkg::REG_CLASS_BITS, 64'd63);
        cfg_write(scl_pkg::REG_FIRST_LINE, 64'd0);
        cfg_write(4'd15, 64'd5);
        cfg_done();

        // Random part: mostly well-formed fragments
        sent = 0;
        while (sent < 35)
        begin
            frag = random_fragment();
            for (int i = 0; i < frag.len(); i++)
            begin
                send_byte(frag[i], $urandom_range(0, 40) == 0);
                sent++;
            end
        end
        send_byte(8'h20, 1'b1);
        drain();

        // Third setting: keywords back, class bits clear; no idling in this part
        cfg_write(4'd0, pack_word("if"));
        cfg_write(4'd1, pack_word("x"));
        cfg_write(scl_pkg::REG_CLASS_BITS, 64'd0);
        cfg_write(scl_pkg::REG_FIRST_LINE, 64'd1);
        cfg_done();
        calm_mode = 1'b1;
        sent = 0;
        while (sent < 30)
        begin
            frag = random_fragment();
            for (int i = 0; i < frag.len(); i++)
            begin
                send_byte(frag[i], 1'b0);
                sent++;
            end
        end
        send_byte(8'h0A, 1'b1);
        drain();

        $display("Covered %0d bytes and %0d tokens over three keyword settings,",
                 lex_board.byte_count, lex_board.token_count);
        $display("with escapes, comments, operators, bad bytes and end of source.");
        if (lex_board.error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
